FILE: rtl/pic_pkg.sv
package pic_pkg;

   // default build values
   localparam int NUM_SOURCES_DEF   = 64;
   localparam int PRIORITY_BITS_DEF = 3;

   // widest source number and widest priority the struct fields carry
   localparam int SRC_W      = 6;
   localparam int PRIO_W_MAX = 8;

   // item actions
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_RAISE = 2'd2;
   localparam logic [1:0] ACT_LOWER = 2'd3;

   // register offsets from the controller base
   localparam logic [25:0] OFF_PEND_LO = 26'h000_1000;
   localparam logic [25:0] OFF_PEND_HI = 26'h000_1004;
   localparam logic [25:0] OFF_MEN_LO  = 26'h000_2000;
   localparam logic [25:0] OFF_MEN_HI  = 26'h000_2004;
   localparam logic [25:0] OFF_SEN_LO  = 26'h000_2080;
   localparam logic [25:0] OFF_SEN_HI  = 26'h000_2084;
   localparam logic [25:0] OFF_THRESH  = 26'h020_0000;
   localparam logic [25:0] OFF_CLAIM   = 26'h020_0004;

   typedef struct packed {
      logic [1:0]  action;
      logic [25:0] reg_offset;
      logic [31:0] write_value;
      logic [5:0]  source_line;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        access_error;
      logic        machine_irq;
      logic        super_irq;
   } rsp_type;

   // priority table write port
   typedef struct packed {
      logic                  en;
      logic [SRC_W-1:0]      idx;
      logic [PRIO_W_MAX-1:0] data;
   } prio_wr_type;

endpackage

FILE: rtl/pic_prio_mem.sv
module pic_prio_mem
   import pic_pkg::*;
#(
   parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [SRC_W-1:0]         rd_idx,
   input  prio_wr_type              wr,
   output logic [PRIORITY_BITS-1:0] rd_data
);

   localparam int IDX_W = $clog2(NUM_SOURCES);

   logic [PRIORITY_BITS-1:0] mem [NUM_SOURCES];
   logic [NUM_SOURCES-1:0]   valid_ff;

   logic                     rd_ok;
   logic                     rd_hit;
   logic [PRIORITY_BITS-1:0] mem_rd_ff;
   logic                     rd_vld_ff;
   logic                     byp_ff;
   logic [PRIORITY_BITS-1:0] byp_data_ff;

   assign rd_ok  = {1'b0, rd_idx} < (SRC_W + 1)'(NUM_SOURCES);
   assign rd_hit = wr.en && (wr.idx == rd_idx);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx[IDX_W-1:0]] <= wr.data[PRIORITY_BITS-1:0];
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_idx[IDX_W-1:0]];
         byp_data_ff <= wr.data[PRIORITY_BITS-1:0];
      end
   end

   // entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.idx[IDX_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= rd_ok && valid_ff[rd_idx[IDX_W-1:0]];
            byp_ff    <= rd_hit;
         end
      end
   end

   always_comb begin
      if (byp_ff) begin
         rd_data = byp_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = mem_rd_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

FILE: rtl/pic_engine.sv
module pic_engine
   import pic_pkg::*;
#(
   parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  req_type                  item,
   input  logic [PRIORITY_BITS-1:0] prio_rd,
   output rsp_type                  rsp,
   output prio_wr_type              prio_wr
);

   localparam int IDX_W = $clog2(NUM_SOURCES);

   logic [NUM_SOURCES-1:0]   pend_ff, pend_in;
   logic [NUM_SOURCES-1:0]   men_ff, men_in;
   logic [NUM_SOURCES-1:0]   sen_ff, sen_in;
   logic [PRIORITY_BITS-1:0] thr_ff, thr_in;
   logic                     mline_ff, mline_in;
   logic                     sline_ff, sline_in;

   logic [63:0]            pend64, men64, sen64, men_wr64, sen_wr64;
   logic [NUM_SOURCES-1:0] low_oh, src_oh;
   logic [SRC_W-1:0]       claim_idx;
   logic                   is_prio, src_ok, is_hi;
   logic [31:0]            rv;
   logic                   err;
   logic [25:0]            off;

   assign off     = item.reg_offset;
   assign is_prio = (off[1:0] == 2'b00) && (off[25:2] < 24'(NUM_SOURCES));
   assign src_ok  = {1'b0, item.source_line} < (SRC_W + 1)'(NUM_SOURCES);
   assign is_hi   = off[2];

   assign pend64 = 64'(pend_ff);
   assign men64  = 64'(men_ff);
   assign sen64  = 64'(sen_ff);

   always_comb begin
      men_wr64 = men64;
      sen_wr64 = sen64;
      if (is_hi) begin
         men_wr64[63:32] = item.write_value;
         sen_wr64[63:32] = item.write_value;
      end else begin
         men_wr64[31:0] = item.write_value;
         sen_wr64[31:0] = item.write_value;
      end
   end

   // lowest pending source, bit 0 never pending
   assign low_oh = pend_ff & (~pend_ff + NUM_SOURCES'(1));

   always_comb begin
      claim_idx = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         if (low_oh[i]) begin
            claim_idx = claim_idx | SRC_W'(i);
         end
      end
   end

   always_comb begin
      src_oh = '0;
      if (src_ok && (item.source_line != '0)) begin
         src_oh[item.source_line[IDX_W-1:0]] = 1'b1;
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      men_in   = men_ff;
      sen_in   = sen_ff;
      thr_in   = thr_ff;
      mline_in = mline_ff;
      sline_in = sline_ff;
      rv       = '0;
      err      = 1'b0;
      prio_wr  = '0;
      unique case (item.action)
         ACT_READ: begin
            if (is_prio) begin
               rv = 32'(prio_rd);
            end else if (off == OFF_PEND_LO) begin
               rv = pend64[31:0];
            end else if (off == OFF_PEND_HI) begin
               rv = pend64[63:32];
            end else if (off == OFF_MEN_LO) begin
               rv = men64[31:0];
            end else if (off == OFF_MEN_HI) begin
               rv = men64[63:32];
            end else if (off == OFF_SEN_LO) begin
               rv = sen64[31:0];
            end else if (off == OFF_SEN_HI) begin
               rv = sen64[63:32];
            end else if (off == OFF_THRESH) begin
               rv = 32'(thr_ff);
            end else if (off == OFF_CLAIM) begin
               if (|pend_ff) begin
                  rv      = 32'(claim_idx);
                  pend_in = pend_ff & ~low_oh;
                  if (pend_in == '0) begin
                     mline_in = 1'b0;
                     sline_in = 1'b0;
                  end
               end
            end else begin
               err = 1'b1;
            end
         end
         ACT_WRITE: begin
            if (is_prio) begin
               prio_wr.en   = go;
               prio_wr.idx  = off[SRC_W+1:2];
               prio_wr.data = item.write_value[PRIO_W_MAX-1:0];
            end else if (off == OFF_PEND_LO || off == OFF_PEND_HI) begin
               err = (item.write_value != '0);
            end else if (off == OFF_MEN_LO || off == OFF_MEN_HI) begin
               men_in = men_wr64[NUM_SOURCES-1:0];
            end else if (off == OFF_SEN_LO || off == OFF_SEN_HI) begin
               sen_in = sen_wr64[NUM_SOURCES-1:0];
            end else if (off == OFF_THRESH) begin
               thr_in = item.write_value[PRIORITY_BITS-1:0];
            end else if (off != OFF_CLAIM) begin
               err = 1'b1;
            end
         end
         ACT_RAISE: begin
            if (src_ok && (prio_rd >= thr_ff)) begin
               pend_in = pend_ff | src_oh;
               if (|(pend_in & men_ff)) begin
                  mline_in = 1'b1;
               end else if (|(pend_in & sen_ff)) begin
                  sline_in = 1'b1;
               end
            end
         end
         ACT_LOWER: begin
            if (src_ok) begin
               pend_in = pend_ff & ~src_oh;
               if (pend_in == '0) begin
                  mline_in = 1'b0;
                  sline_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.read_value   = rv;
   assign rsp.access_error = err;
   assign rsp.machine_irq  = mline_in;
   assign rsp.super_irq    = sline_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         men_ff   <= '0;
         sen_ff   <= '0;
         thr_ff   <= '0;
         mline_ff <= 1'b0;
         sline_ff <= 1'b0;
      end else if (go) begin
         pend_ff  <= pend_in;
         men_ff   <= men_in;
         sen_ff   <= sen_in;
         thr_ff   <= thr_in;
         mline_ff <= mline_in;
         sline_ff <= sline_in;
      end
   end

   a_src0_never_pending: assert property (@(posedge clock) disable iff (reset)
      !pend_ff[0])
      else $error("source 0 became pending");

   a_lines_rise_on_raise: assert property (@(posedge clock) disable iff (reset)
      go && (item.action != ACT_RAISE) |=> !$rose(mline_ff) && !$rose(sline_ff))
      else $error("interrupt line rose without a raise");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(pend_ff) && $stable(mline_ff) && $stable(sline_ff))
      else $error("state changed without an item");

   a_error_on_bus_only: assert property (@(posedge clock) disable iff (reset)
      rsp.access_error |-> item.action == ACT_READ || item.action == ACT_WRITE)
      else $error("error flagged on a source event");

endmodule

FILE: rtl/platform_interrupt_controller.sv
// channel   ports                                  item
// request   req_valid, req_stall, req_payload      action, reg_offset, write_value, source_line
// response  rsp_valid, rsp_stall, rsp_payload      read_value, access_error, irq levels
//
// one item per cycle sustained while rsp_stall is low; a taken item is held in the input register
// while the priority table is read, and the response register is loaded as it moves on to rsp
// reset clears pending bits, enables, threshold and lines; the priority table reads zero
// until written, so no clearing pass is needed
// a stalled response holds one item while the next waits in the input register
module platform_interrupt_controller
   import pic_pkg::*;
#(
   parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // input register
   logic    in_vld_ff, in_vld_in;
   req_type in_ff;

   // response register
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff;

   logic                     req_take;
   logic                     advance;
   logic [SRC_W-1:0]         rd_idx;
   logic [PRIORITY_BITS-1:0] prio_rd;
   prio_wr_type              prio_wr;
   rsp_type                  rsp_next;

   // the held item moves on when the response register is free or draining
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // a raise looks up its source priority, a bus access the addressed entry
   assign rd_idx = (req_payload.action == ACT_RAISE) ? req_payload.source_line
                                                     : req_payload.reg_offset[SRC_W+1:2];

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   // priority table, read as the item is taken, written as the item completes;
   // a write to the entry being read is forwarded
   pic_prio_mem #(
      .NUM_SOURCES   (NUM_SOURCES),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_prio_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_idx  (rd_idx),
      .wr      (prio_wr),
      .rd_data (prio_rd)
   );

   // decode, pending and claim logic, interrupt lines
   pic_engine #(
      .NUM_SOURCES   (NUM_SOURCES),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .go      (advance),
      .item    (in_ff),
      .prio_rd (prio_rd),
      .rsp     (rsp_next),
      .prio_wr (prio_wr)
   );

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule

FILE: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pic_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   localparam int PHASE_ITEMS  = 234;   // three random phases, about 700 items in all
   localparam int QUIET_LIMIT  = 5000;  // cycles with no item moving on either channel
   localparam int TAIL_CYCLES  = 8;     // pipeline is two deep, leave some margin
   localparam int NSRC         = NUM_SOURCES_DEF;
   localparam int PBITS        = PRIORITY_BITS_DEF;

   // stimulus side, every input known from time zero
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_stall   = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_payload;

   // idle and stall rates in percent, per random phase
   int send_idle_tbl [3] = '{14, 71, 0};
   int recv_stall_tbl [3] = '{71, 14, 0};
   int idle_pct  = 0;
   int stall_pct = 0;

   // shadow copy of the controller state
   logic [PBITS-1:0] prio_tbl [NSRC];
   logic [63:0]      pend_bits;
   logic [63:0]      men_mask;
   logic [63:0]      sen_mask;
   logic [PBITS-1:0] thresh_lvl;
   logic             m_line;
   logic             s_line;

   // responses still owed by the block, oldest first
   rsp_type due_rsp_q [$];

   // one row of the directed table
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;
   stim_row_type dir_rows [$];

   int  fail_cnt      = 0;
   int  items_sent    = 0;
   int  rsp_checked   = 0;
   int  claims_won    = 0;
   int  m_high_seen   = 0;
   int  s_high_seen   = 0;
   int  quiet_cycles  = 0;
   bit  finished      = 1'b0;

   platform_interrupt_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // both lines fall once nothing is pending any more
   function automatic void drop_lines_if_idle();
      if (pend_bits == '0) begin
         m_line = 1'b0;
         s_line = 1'b0;
      end
   endfunction

   // next response of the controller for one item, advancing the shadow state
   function automatic rsp_type predict_rsp(req_type r);
      rsp_type     o;
      logic [25:0] off;
      logic        prio_hit;
      logic        found;
      o        = '0;
      off      = r.reg_offset;
      prio_hit = (off[1:0] == 2'b00) && ((off >> 2) < NSRC);
      found    = 1'b0;
      case (r.action)
         ACT_READ: begin
            if (prio_hit) begin
               o.read_value = 32'(prio_tbl[off[7:2]]);
            end else begin
               case (off)
                  OFF_PEND_LO: o.read_value = pend_bits[31:0];
                  OFF_PEND_HI: o.read_value = pend_bits[63:32];
                  OFF_MEN_LO:  o.read_value = men_mask[31:0];
                  OFF_MEN_HI:  o.read_value = men_mask[63:32];
                  OFF_SEN_LO:  o.read_value = sen_mask[31:0];
                  OFF_SEN_HI:  o.read_value = sen_mask[63:32];
                  OFF_THRESH:  o.read_value = 32'(thresh_lvl);
                  OFF_CLAIM: begin
                     // lowest pending source above zero wins
                     for (int i = 1; i < NSRC; i++) begin
                        if (!found && pend_bits[i]) begin
                           found        = 1'b1;
                           pend_bits[i] = 1'b0;
                           o.read_value = 32'(i);
                        end
                     end
                     if (found) begin
                        claims_won++;
                        drop_lines_if_idle();
                     end
                  end
                  default: o.access_error = 1'b1;
               endcase
            end
         end
         ACT_WRITE: begin
            if (prio_hit) begin
               prio_tbl[off[7:2]] = r.write_value[PBITS-1:0];
            end else begin
               case (off)
                  OFF_PEND_LO, OFF_PEND_HI: o.access_error = (r.write_value != '0);
                  OFF_MEN_LO: men_mask[31:0]  = r.write_value;
                  OFF_MEN_HI: men_mask[63:32] = r.write_value;
                  OFF_SEN_LO: sen_mask[31:0]  = r.write_value;
                  OFF_SEN_HI: sen_mask[63:32] = r.write_value;
                  OFF_THRESH: thresh_lvl      = r.write_value[PBITS-1:0];
                  OFF_CLAIM:  ;
                  default:    o.access_error = 1'b1;
               endcase
            end
         end
         ACT_RAISE: begin
            if (r.source_line < NSRC && prio_tbl[r.source_line] >= thresh_lvl) begin
               if (r.source_line != '0) begin
                  pend_bits[r.source_line] = 1'b1;
               end
               // machine side takes precedence, lines never drop here
               if ((pend_bits & men_mask) != '0) begin
                  m_line = 1'b1;
               end else if ((pend_bits & sen_mask) != '0) begin
                  s_line = 1'b1;
               end
            end
         end
         default: begin
            if (r.source_line < NSRC) begin
               if (r.source_line != '0) begin
                  pend_bits[r.source_line] = 1'b0;
               end
               drop_lines_if_idle();
            end
         end
      endcase
      o.machine_irq = m_line;
      o.super_irq   = s_line;
      return o;
   endfunction

   function automatic void add_row(logic [1:0] act, logic [25:0] off, logic [31:0] data,
                                   logic [5:0] src, bit typed, logic [31:0] rv, logic err);
      stim_row_type row;
      row.req.action      = act;
      row.req.reg_offset  = off;
      row.req.write_value = data;
      row.req.source_line = src;
      row.typed           = typed;
      // every typed row sits where both lines are known to be low
      row.want            = '{read_value: rv, access_error: err, machine_irq: 1'b0,
                              super_irq: 1'b0};
      dir_rows = {dir_rows, row};
   endfunction

   // register offset, weighted toward the claim port and the real registers
   function automatic logic [25:0] random_offset();
      logic [25:0] off;
      case ($urandom_range(15))
         0, 1, 2:     off = 26'($urandom_range(NSRC - 1) * 4);
         3:           off = $urandom_range(1) ? OFF_PEND_LO : OFF_PEND_HI;
         4:           off = $urandom_range(1) ? OFF_MEN_LO : OFF_MEN_HI;
         5:           off = $urandom_range(1) ? OFF_SEN_LO : OFF_SEN_HI;
         6:           off = OFF_THRESH;
         7, 8, 9, 10: off = OFF_CLAIM;
         // misaligned priority access
         11:          off = 26'($urandom_range(NSRC - 1) * 4 + $urandom_range(3, 1));
         // aligned, just past the priority table
         12:          off = 26'(NSRC * 4 + $urandom_range(1000) * 4);
         default:     off = 26'($urandom);
      endcase
      return off;
   endfunction

   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      pick          = $urandom_range(99);
      r.write_value = $urandom;
      r.reg_offset  = random_offset();
      // half the events hit a small group of sources so claims and lowers collide
      r.source_line = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      if (pick < 30) begin
         r.action = ACT_RAISE;
      end else if (pick < 40) begin
         r.action = ACT_LOWER;
      end else if (pick < 70) begin
         r.action = ACT_READ;
      end else begin
         r.action = ACT_WRITE;
      end
      // pending writes of zero are legal, give them a fair share
      if (r.action == ACT_WRITE && (r.reg_offset == OFF_PEND_LO || r.reg_offset == OFF_PEND_HI)
          && $urandom_range(1)) begin
         r.write_value = '0;
      end
      // keep the threshold low often enough that raises get through
      if (r.action == ACT_WRITE && r.reg_offset == OFF_THRESH && $urandom_range(1)) begin
         r.write_value[PBITS-1:0] = '0;
      end
      return r;
   endfunction

   // present one item, hold it until taken, then record what it should produce
   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // taken at this edge; the state still advances on typed rows
      predicted = predict_rsp(r);
      if (typed) begin
         predicted = typed_rsp;
      end
      due_rsp_q = {due_rsp_q, predicted};
      items_sent++;
   endtask

   // sender holds off until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_cnt++;
      end
   endtask

   // response side: check every item taken, then choose the next stall
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (due_rsp_q.size() == 0) begin
            $error("response item with nothing expected: %0h", rsp_payload);
            fail_cnt++;
         end else begin
            want = due_rsp_q.pop_front();
            compare_field("read_value", want.read_value, rsp_payload.read_value);
            compare_field("access_error", 32'(want.access_error), 32'(rsp_payload.access_error));
            compare_field("machine_irq", 32'(want.machine_irq), 32'(rsp_payload.machine_irq));
            compare_field("super_irq", 32'(want.super_irq), 32'(rsp_payload.super_irq));
            rsp_checked++;
            if (rsp_payload.machine_irq === 1'b1) m_high_seen++;
            if (rsp_payload.super_irq === 1'b1) s_high_seen++;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // watchdog on channel activity
   always @(posedge clock) begin
      if (reset || finished) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("channels quiet for %0d cycles, %0d responses owed",
                  quiet_cycles, due_rsp_q.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // shadow state matches the block after reset
      foreach (prio_tbl[i]) prio_tbl[i] = '0;
      pend_bits  = '0;
      men_mask   = '0;
      sen_mask   = '0;
      thresh_lvl = '0;
      m_line     = 1'b0;
      s_line     = 1'b0;

      // directed table: typed results only where they are obvious
      add_row(ACT_READ,  OFF_THRESH,   32'h0,        6'd0,  1'b1, 32'h0, 1'b0);
      add_row(ACT_READ,  OFF_PEND_LO,  32'h0,        6'd0,  1'b1, 32'h0, 1'b0);
      // unknown address, both directions
      add_row(ACT_READ,  26'h3FF_FFFF, 32'h0,        6'd63, 1'b1, 32'h0, 1'b1);
      add_row(ACT_WRITE, 26'h000_0100, 32'hFFFF_FFFF, 6'd0, 1'b1, 32'h0, 1'b1);
      // pending is read only: non-zero write flags, zero write passes
      add_row(ACT_WRITE, OFF_PEND_LO,  32'hFFFF_FFFF, 6'd0, 1'b1, 32'h0, 1'b1);
      add_row(ACT_WRITE, OFF_PEND_HI,  32'h0,        6'd0,  1'b1, 32'h0, 1'b0);
      // completion write is ignored
      add_row(ACT_WRITE, OFF_CLAIM,    32'hFFFF_FFFF, 6'd0, 1'b1, 32'h0, 1'b0);
      // top source gets the highest priority, masked to the field width
      add_row(ACT_WRITE, 26'h000_00FC, 32'hFFFF_FFFF, 6'd0, 1'b1, 32'h0, 1'b0);
      add_row(ACT_READ,  26'h000_00FC, 32'h0,        6'd0,  1'b1, 32'h7, 1'b0);
      // source 5 below the threshold is ignored
      add_row(ACT_WRITE, 26'h000_0014, 32'h2,        6'd0,  1'b0, 32'h0, 1'b0);
      add_row(ACT_WRITE, OFF_THRESH,   32'hFFFF_FFFB, 6'd0, 1'b0, 32'h0, 1'b0);
      add_row(ACT_RAISE, 26'h0,        32'h0,        6'd5,  1'b0, 32'h0, 1'b0);
      add_row(ACT_WRITE, OFF_MEN_HI,   32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 1'b0);
      add_row(ACT_WRITE, OFF_SEN_LO,   32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 1'b0);
      add_row(ACT_WRITE, OFF_THRESH,   32'h0,        6'd0,  1'b0, 32'h0, 1'b0);
      // source zero passes the threshold but never goes pending
      add_row(ACT_RAISE, 26'h0,        32'h0,        6'd0,  1'b0, 32'h0, 1'b0);
      // supervisor line from source 5, machine line from source 63
      add_row(ACT_RAISE, 26'h0,        32'h0,        6'd5,  1'b0, 32'h0, 1'b0);
      add_row(ACT_RAISE, 26'h0,        32'h0,        6'd63, 1'b0, 32'h0, 1'b0);
      add_row(ACT_READ,  OFF_PEND_HI,  32'h0,        6'd0,  1'b0, 32'h0, 1'b0);
      // misaligned priority offset
      add_row(ACT_READ,  26'h000_0002, 32'h0,        6'd0,  1'b0, 32'h0, 1'b0);
      add_row(ACT_READ,  OFF_CLAIM,    32'h0,        6'd0,  1'b0, 32'h0, 1'b0);
      // raise with no pending source enabled keeps both lines up
      add_row(ACT_WRITE, OFF_MEN_HI,   32'h0,        6'd0,  1'b0, 32'h0, 1'b0);
      add_row(ACT_RAISE, 26'h0,        32'h0,        6'd40, 1'b0, 32'h0, 1'b0);
      // lower that leaves something pending, then the one that empties it
      add_row(ACT_LOWER, 26'h0,        32'h0,        6'd63, 1'b0, 32'h0, 1'b0);
      add_row(ACT_LOWER, 26'h0,        32'h0,        6'd40, 1'b0, 32'h0, 1'b0);
      // claim with nothing pending
      add_row(ACT_READ,  OFF_CLAIM,    32'h0,        6'd0,  1'b0, 32'h0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part runs with no idling on either side
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
      drain();

      // random phases: slow receiver, then slow sender, then full rate
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct  = send_idle_tbl[ph];
         stall_pct = recv_stall_tbl[ph];
         repeat (PHASE_ITEMS) send_item(random_req(), 1'b0, '0);
         drain();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      finished = 1'b1;

      if (due_rsp_q.size() != 0) begin
         $error("%0d response items never arrived", due_rsp_q.size());
         fail_cnt++;
      end

      $display("%0d items driven (%0d from the directed table), %0d responses compared",
               items_sent, dir_rows.size(), rsp_checked);
      $display("%0d claims granted; %0d responses with machine line high, %0d with supervisor",
               claims_won, m_high_seen, s_high_seen);
      if (fail_cnt == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
